[sv/stt_pkg.sv]
`timescale 1ns / 1ps

package stt_pkg;

   // ENTRIES must be a power of two: the index is the low key bits.
   localparam int ENTRIES     = 4096;
   localparam int OCC_SAMPLES = 1000;
   localparam int MAX_PLY     = 64;

   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int OCC_N   = (OCC_SAMPLES < ENTRIES) ? OCC_SAMPLES : ENTRIES;
   localparam int OCC_CW  = $clog2(OCC_N + 1);

   localparam logic [14:0] MATE_THR_RESET = 15'd29936;
   localparam int          SCORE_SAT      = 32767;

   localparam logic [2:0] CMD_STORE  = 3'd0;
   localparam logic [2:0] CMD_PROBE  = 3'd1;
   localparam logic [2:0] CMD_LOOKUP = 3'd2;
   localparam logic [2:0] CMD_CLEAR  = 3'd3;
   localparam logic [2:0] CMD_OCC    = 3'd4;

   localparam logic [1:0] BOUND_UPPER = 2'd0;
   localparam logic [1:0] BOUND_LOWER = 2'd1;
   localparam logic [1:0] BOUND_EXACT = 2'd2;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EVAL,
      ST_CLEAR,
      ST_OCC,
      ST_OCC_DRAIN,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [63:0]        key;
      logic [24:0]        move;
      logic signed [15:0] score;
      logic [5:0]         depth;
      logic [1:0]         bound;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // last declared field in the lowest bits
   typedef struct packed {
      logic [5:0]         pad;
      logic [5:0]         ply;
      logic signed [15:0] beta;
      logic signed [15:0] alpha;
      logic [5:0]         depth;
      logic [1:0]         bound;
      logic signed [15:0] score_in;
      logic [24:0]        move_in;
      logic [63:0]        key;
      logic [2:0]         cmd;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]         pad;
      logic [31:0]        hit_count;
      logic [31:0]        overwrite_count;
      logic [31:0]        new_write_count;
      logic [9:0]         occupancy;
      logic signed [15:0] score_out;
      logic [24:0]        move_out;
      logic               cutoff;
      logic               found;
   } rsp_payload_type;

   localparam int REQ_TDATA_W = $bits(req_payload_type);
   localparam int RSP_TDATA_W = $bits(rsp_payload_type);

   // outward when storing, inward when reading; saturated to +/-SCORE_SAT
   function automatic logic [15:0] mate_adjust(input logic signed [15:0] s,
                                               input logic [14:0] thr,
                                               input logic [5:0] ply,
                                               input logic inward);
      logic signed [17:0] sx;
      logic signed [17:0] tx;
      logic signed [17:0] px;
      logic signed [17:0] r;
      sx = 18'(s);
      tx = $signed({3'b000, thr});
      px = $signed({12'd0, ply});
      r  = sx;
      if (sx > tx) begin
         r = inward ? (sx - px) : (sx + px);
      end else if (sx < -tx) begin
         r = inward ? (sx + px) : (sx - px);
      end
      if (r > 18'(SCORE_SAT)) begin
         r = 18'(SCORE_SAT);
      end else if (r < -18'(SCORE_SAT)) begin
         r = -18'(SCORE_SAT);
      end
      return r[15:0];
   endfunction

endpackage

[sv/stt_ram.sv]
`timescale 1ns / 1ps

module stt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/search_transposition_table_core.sv]
`timescale 1ns / 1ps
// Store, probe, best-move lookup: memory read, evaluate/write back, then result,
// one request at a time; the result is held while the response output stalls.
// A new request is taken only once the previous one has left the result state.
// Clear: one memory row per cycle. Occupancy: a sweep over the first OCC_N rows.
// Reset (synchronous) starts a clearing pass over every row; requests wait for it.
// The configuration register is always ready and resets to 29936.

module search_transposition_table_core (
   input  logic                             clock,
   input  logic                             reset,
   // cmd, key, move_in, score_in, bound, depth, alpha, beta, ply, zero pad
   input  logic [stt_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // found, cutoff, move_out, score_out, occupancy, new_write_count,
   // overwrite_count, hit_count, zero pad
   output logic [stt_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [14:0]                      csr_data,
   input  logic                             csr_valid,
   output logic                             csr_ready
);

   import stt_pkg::*;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);
   localparam logic [IDX_W-1:0] OCC_LAST = IDX_W'(OCC_N - 1);
   localparam logic [6:0]       PLY_LIM  = 7'(MAX_PLY - 1);

   state_type        state_ff, state_in;
   req_payload_type  req_pl;
   req_payload_type  req_ff, req_in;
   logic [14:0]      thr_ff, thr_in;
   logic [IDX_W-1:0] sweep_ff, sweep_in;
   logic             occ_vld_ff, occ_vld_in;
   logic [OCC_CW-1:0] occ_cnt_ff, occ_cnt_in;
   logic [31:0]      new_ff, new_in;
   logic [31:0]      over_ff, over_in;
   logic [31:0]      hits_ff, hits_in;

   logic             res_found_ff, res_found_in;
   logic             res_hit_ff, res_hit_in;
   logic [24:0]      res_move_ff, res_move_in;
   logic [15:0]      res_score_ff, res_score_in;
   logic [1:0]       res_bound_ff, res_bound_in;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_ff, rsp_in;

   logic             req_fire;
   logic             rsp_free;
   logic [5:0]       ply_cl;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_entry;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_entry;
   logic [ENTRY_W-1:0] rd_raw;

   logic             out_cut;
   logic signed [15:0] out_score;
   logic [9:0]       occ_sat;

   assign req_pl   = req_payload_type'(req_tdata);
   assign req_fire = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign ply_cl   = ({1'b0, req_ff.ply} > PLY_LIM) ? PLY_LIM[5:0] : req_ff.ply;
   assign rd_entry = entry_type'(rd_raw);

   stt_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (sweep_ff == IDX_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (req_pl.cmd)
                  CMD_STORE, CMD_PROBE, CMD_LOOKUP: state_in = ST_EVAL;
                  CMD_CLEAR:                        state_in = ST_CLEAR;
                  CMD_OCC:                          state_in = ST_OCC;
                  default:                          state_in = ST_RESULT;
               endcase
            end
         end
         ST_EVAL:      state_in = ST_RESULT;
         ST_CLEAR: begin
            if (sweep_ff == IDX_LAST) state_in = ST_RESULT;
         end
         ST_OCC: begin
            if (sweep_ff == OCC_LAST) state_in = ST_OCC_DRAIN;
         end
         ST_OCC_DRAIN: state_in = ST_RESULT;
         ST_RESULT: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default:      state_in = ST_INIT;
      endcase
   end

   // memory control and handshakes
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      csr_ready  = 1'b1;
      rd_addr    = (state_ff == ST_IDLE) ? req_pl.key[IDX_W-1:0] : sweep_ff;
      wr_en      = 1'b0;
      wr_addr    = sweep_ff;
      wr_entry   = '0;
      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            wr_en = 1'b1;
         end
         ST_EVAL: begin
            if (req_ff.cmd == CMD_STORE) begin
               wr_en          = 1'b1;
               wr_addr        = req_ff.key[IDX_W-1:0];
               wr_entry.key   = req_ff.key;
               wr_entry.move  = req_ff.move_in;
               wr_entry.score = mate_adjust(req_ff.score_in, thr_ff, ply_cl, 1'b0);
               wr_entry.depth = req_ff.depth;
               wr_entry.bound = req_ff.bound;
            end
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      req_in       = req_ff;
      thr_in       = csr_valid ? csr_data : thr_ff;
      sweep_in     = sweep_ff;
      occ_vld_in   = (state_ff == ST_OCC);
      occ_cnt_in   = occ_cnt_ff;
      new_in       = new_ff;
      over_in      = over_ff;
      hits_in      = hits_ff;
      res_found_in = res_found_ff;
      res_hit_in   = res_hit_ff;
      res_move_in  = res_move_ff;
      res_score_in = res_score_ff;
      res_bound_in = res_bound_ff;

      if (state_ff == ST_INIT || state_ff == ST_CLEAR || state_ff == ST_OCC) begin
         sweep_in = sweep_ff + 1'b1;
      end
      if (occ_vld_ff && rd_entry.move != '0) begin
         occ_cnt_in = occ_cnt_ff + 1'b1;
      end

      if (req_fire) begin
         req_in       = req_pl;
         sweep_in     = '0;
         occ_cnt_in   = '0;
         res_found_in = 1'b0;
         res_hit_in   = 1'b0;
         res_move_in  = '0;
         if (req_pl.cmd == CMD_CLEAR) new_in = '0;
      end

      if (state_ff == ST_EVAL) begin
         res_score_in = mate_adjust(rd_entry.score, thr_ff, ply_cl, 1'b1);
         res_bound_in = rd_entry.bound;
         if (req_ff.cmd == CMD_STORE) begin
            if (rd_entry.key == '0) new_in = new_ff + 1'b1;
            else                    over_in = over_ff + 1'b1;
         end else if (rd_entry.key == req_ff.key) begin
            res_found_in = 1'b1;
            res_move_in  = rd_entry.move;
            if (req_ff.cmd == CMD_PROBE && rd_entry.depth >= req_ff.depth) begin
               res_hit_in = 1'b1;
               hits_in    = hits_ff + 1'b1;
            end
         end
      end
   end

   // bound rule and result register
   always_comb begin
      out_cut   = 1'b0;
      out_score = $signed(res_score_ff);
      case (res_bound_ff)
         BOUND_UPPER: begin
            if ($signed(res_score_ff) <= req_ff.alpha) begin
               out_score = req_ff.alpha;
               out_cut   = 1'b1;
            end
         end
         BOUND_LOWER: begin
            if ($signed(res_score_ff) >= req_ff.beta) begin
               out_score = req_ff.beta;
               out_cut   = 1'b1;
            end
         end
         BOUND_EXACT: out_cut = 1'b1;
         default:     out_cut = 1'b0;
      endcase
      if (!res_hit_ff) begin
         out_cut   = 1'b0;
         out_score = '0;
      end

      occ_sat = (occ_cnt_ff > OCC_CW'(1023)) ? 10'd1023 : 10'(occ_cnt_ff);

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (state_ff == ST_RESULT && rsp_free) begin
         rsp_valid_in           = 1'b1;
         rsp_in.pad             = '0;
         rsp_in.found           = res_found_ff;
         rsp_in.cutoff          = out_cut;
         rsp_in.move_out        = res_move_ff;
         rsp_in.score_out       = out_score;
         rsp_in.occupancy       = occ_sat;
         rsp_in.new_write_count = new_ff;
         rsp_in.overwrite_count = over_ff;
         rsp_in.hit_count       = hits_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         thr_ff       <= MATE_THR_RESET;
         sweep_ff     <= '0;
         occ_vld_ff   <= 1'b0;
         new_ff       <= '0;
         over_ff      <= '0;
         hits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         sweep_ff     <= sweep_in;
         occ_vld_ff   <= occ_vld_in;
         new_ff       <= new_in;
         over_ff      <= over_in;
         hits_ff      <= hits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      occ_cnt_ff   <= occ_cnt_in;
      res_found_ff <= res_found_in;
      res_hit_ff   <= res_hit_in;
      res_move_ff  <= res_move_in;
      res_score_ff <= res_score_in;
      res_bound_ff <= res_bound_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   a_init_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT || state_ff == ST_CLEAR) |-> !req_tready)
      else $error("request taken during clearing pass");

   a_cut_needs_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.cutoff) |-> rsp_ff.found)
      else $error("cutoff without key match");

   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.occupancy <= 10'(OCC_N)))
      else $error("occupancy above sample count");

   a_result_after_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |=> (state_ff == ST_RESULT))
      else $error("evaluate did not lead to result");

endmodule

[verif/search_transposition_table_core_tb.sv]
`timescale 1ns / 1ps

module search_transposition_table_core_tb;
   import stt_pkg::*;

   localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
   localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;
   localparam logic [1:0] BOUND_NONE     = 2'd3;
   localparam int         HOLD_CYCLES    = 300;
   localparam int         WATCHDOG_LIMIT = 30000;
   localparam int         ITEMS_PER_LEG  = 112;

   class table_scoreboard;
      logic [63:0]        tab_key   [ENTRIES];
      logic [24:0]        tab_move  [ENTRIES];
      logic signed [15:0] tab_score [ENTRIES];
      logic [5:0]         tab_depth [ENTRIES];
      logic [1:0]         tab_bound [ENTRIES];
      logic [31:0]        new_writes;
      logic [31:0]        overwrites;
      logic [31:0]        hits;
      int                 thr;
      int                 thr_writes;
      int                 errors;
      int                 checked;
      rsp_payload_type    expected_rsp[$];

      function new();
         wipe_table();
         overwrites = '0;
         hits       = '0;
         thr        = int'(MATE_THR_RESET);
      endfunction

      function void wipe_table();
         for (int i = 0; i < ENTRIES; i++) begin
            tab_key[i]   = '0;
            tab_move[i]  = '0;
            tab_score[i] = '0;
            tab_depth[i] = '0;
            tab_bound[i] = '0;
         end
         new_writes = '0;
      endfunction

      function int clip_score(int s);
         if (s > SCORE_SAT) return SCORE_SAT;
         if (s < -SCORE_SAT) return -SCORE_SAT;
         return s;
      endfunction

      function void set_threshold(logic [14:0] v);
         thr = int'(v);
         thr_writes++;
      endfunction

      function void apply_command(req_payload_type r);
         int              ix;
         int              p;
         int              s;
         int unsigned     n;
         rsp_payload_type e;
         e  = '0;
         ix = int'(r.key[IDX_W-1:0]);
         p  = int'(r.ply);
         if (p > MAX_PLY - 1) p = MAX_PLY - 1;
         case (r.cmd)
            CMD_STORE: begin
               if (tab_key[ix] == '0) new_writes++;
               else overwrites++;
               s = r.score_in;
               if (s > thr) s = s + p;
               else if (s < -thr) s = s - p;
               tab_key[ix]   = r.key;
               tab_move[ix]  = r.move_in;
               tab_score[ix] = 16'(clip_score(s));
               tab_depth[ix] = r.depth;
               tab_bound[ix] = r.bound;
            end
            CMD_PROBE, CMD_LOOKUP: begin
               if (tab_key[ix] == r.key) begin
                  e.found    = 1'b1;
                  e.move_out = tab_move[ix];
                  if (r.cmd == CMD_PROBE && tab_depth[ix] >= r.depth) begin
                     hits++;
                     s = tab_score[ix];
                     if (s > thr) s = s - p;
                     else if (s < -thr) s = s + p;
                     s = clip_score(s);
                     case (tab_bound[ix])
                        BOUND_UPPER: begin
                           if (s <= int'(r.alpha)) begin
                              s        = r.alpha;
                              e.cutoff = 1'b1;
                           end
                        end
                        BOUND_LOWER: begin
                           if (s >= int'(r.beta)) begin
                              s        = r.beta;
                              e.cutoff = 1'b1;
                           end
                        end
                        BOUND_EXACT: e.cutoff = 1'b1;
                        default: ;
                     endcase
                     e.score_out = 16'(s);
                  end
               end
            end
            CMD_CLEAR: wipe_table();
            CMD_OCC: begin
               n = 0;
               for (int i = 0; i < OCC_N; i++) begin
                  if (tab_move[i] != '0) n++;
               end
               e.occupancy = (n > 1023) ? 10'd1023 : 10'(n);
            end
            default: ;
         endcase
         e.new_write_count = new_writes;
         e.overwrite_count = overwrites;
         e.hit_count       = hits;
         expected_rsp.push_back(e);
      endfunction

      function void compare(string name, logic [63:0] ev, logic [63:0] av);
         if (ev !== av) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, ev, av);
            errors++;
         end
      endfunction

      function void check_response(rsp_payload_type a);
         rsp_payload_type e;
         if (expected_rsp.size() == 0) begin
            $display("%0t: response with nothing outstanding, expected none actual %h",
                     $time, a);
            errors++;
            return;
         end
         e = expected_rsp.pop_front();
         checked++;
         compare("found", 64'(e.found), 64'(a.found));
         compare("cutoff", 64'(e.cutoff), 64'(a.cutoff));
         compare("move_out", 64'(e.move_out), 64'(a.move_out));
         compare("score_out", 64'(unsigned'(e.score_out)), 64'(unsigned'(a.score_out)));
         compare("occupancy", 64'(e.occupancy), 64'(a.occupancy));
         compare("new_write_count", 64'(e.new_write_count), 64'(a.new_write_count));
         compare("overwrite_count", 64'(e.overwrite_count), 64'(a.overwrite_count));
         compare("hit_count", 64'(e.hit_count), 64'(a.hit_count));
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [14:0]            csr_data;
   logic                   csr_valid;
   logic                   csr_ready;

   table_scoreboard sb;
   int              tx_idle_pct;
   int              rx_stall_pct;
   int              cur_thr;
   int              hold_seq;
   int              hold_done;
   int              hold_left;
   int              quiet;
   int              items_sent;
   logic [63:0]     key_pool[$];

   search_transposition_table_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.apply_command(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (csr_valid && csr_ready) sb.set_threshold(csr_data);
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_seq != hold_done) begin
         hold_done  <= hold_seq;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, quiet);
         $display("simulation failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   function automatic req_payload_type mk(logic [2:0] cmd, logic [63:0] key,
                                          logic [24:0] mv, int score, logic [1:0] bnd,
                                          logic [5:0] dep, int alpha, int beta,
                                          logic [5:0] ply);
      req_payload_type r;
      r          = '0;
      r.cmd      = cmd;
      r.key      = key;
      r.move_in  = mv;
      r.score_in = 16'(score);
      r.bound    = bnd;
      r.depth    = dep;
      r.alpha    = 16'(alpha);
      r.beta     = 16'(beta);
      r.ply      = ply;
      return r;
   endfunction

   function automatic logic signed [15:0] pick_score();
      int v;
      case ($urandom_range(9))
         0: return 16'($urandom);
         1, 2: begin
            v = cur_thr - 40 + int'($urandom_range(80));
            if (v > SCORE_SAT) v = SCORE_SAT;
         end
         3: v = int'($urandom_range(SCORE_SAT)) % 81 + SCORE_SAT - 80;
         default: return 16'(int'($urandom_range(64000)) - 32000);
      endcase
      if ($urandom_range(1) == 1) v = -v;
      return 16'(v);
   endfunction

   function automatic logic [63:0] pick_key();
      int          c;
      logic [63:0] k;
      c = $urandom_range(99);
      if (c < 45 && key_pool.size() > 0) return key_pool[$urandom_range(key_pool.size() - 1)];
      if (c < 50) return '0;
      k = {$urandom, $urandom};
      if (c < 60) return k;
      if (c < 90) k[IDX_W-1:0] = IDX_W'($urandom_range(23));
      return k;
   endfunction

   function automatic req_payload_type make_item();
      req_payload_type r;
      int              c;
      r = '0;
      c = $urandom_range(199);
      if (c < 80) r.cmd = CMD_STORE;
      else if (c < 150) r.cmd = CMD_PROBE;
      else if (c < 175) r.cmd = CMD_LOOKUP;
      else if (c < 186) r.cmd = CMD_OCC;
      else if (c < 188) r.cmd = CMD_CLEAR;
      else r.cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      r.key      = pick_key();
      r.move_in  = ($urandom_range(9) == 0) ? '0 : 25'($urandom);
      r.score_in = pick_score();
      r.bound    = ($urandom_range(9) == 0) ? BOUND_NONE : 2'($urandom_range(2));
      r.depth    = 6'($urandom);
      r.alpha    = ($urandom_range(3) == 0) ? pick_score() :
                   16'(int'($urandom_range(64000)) - 32000);
      r.beta     = ($urandom_range(3) == 0) ? pick_score() :
                   16'(int'($urandom_range(64000)) - 32000);
      r.ply      = 6'($urandom);
      if (r.cmd == CMD_STORE) begin
         key_pool.push_back(r.key);
         if (key_pool.size() > 48) void'(key_pool.pop_front());
      end
      return r;
   endfunction

   // leaves tvalid high after the transaction; release_req lowers it
   task automatic send_item(input req_payload_type r);
      if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_tdata  <= r;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic release_req();
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drain();
      do @(posedge clock); while (sb.expected_rsp.size() != 0);
   endtask

   task automatic write_threshold(input logic [14:0] v);
      release_req();
      wait_drain();
      csr_data  <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_thr = int'(v);
   endtask

   task automatic run_random(input int count);
      repeat (count) send_item(make_item());
   endtask

   task automatic pressure_burst();
      int saved;
      saved       = tx_idle_pct;
      tx_idle_pct = 0;
      hold_seq++;
      repeat (30) send_item(make_item());
      tx_idle_pct = saved;
   endtask

   initial begin
      logic [63:0] k_a;
      logic [63:0] k_b;
      logic [63:0] k_c;
      logic [63:0] k_d;
      logic [14:0] first_thr[4];
      logic [14:0] second_thr[4];
      int          tx_pct[4];
      int          rx_pct[4];
      k_a        = 64'hFFFF_FFFF_FFFF_FFFF;
      k_b        = 64'h8000_0000_0000_0005;
      k_c        = 64'h0123_4567_89AB_C005;
      k_d        = 64'h5A5A_0000_0000_0007;
      first_thr  = '{15'd0, 15'd32767, 15'd32000, 15'($urandom)};
      second_thr = '{MATE_THR_RESET, 15'd1, 15'($urandom), 15'd16384};
      tx_pct     = '{0, 46, 0, 35};
      rx_pct     = '{0, 0, 46, 35};
      sb           = new();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      cur_thr      = int'(MATE_THR_RESET);
      hold_seq     = 0;
      hold_done    = 0;
      hold_left    = 0;
      quiet        = 0;
      items_sent   = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-entry match, saturation, bound rules, mate adjust, clear
      send_item(mk(CMD_PROBE, '0, '0, 0, BOUND_UPPER, 6'd0, 0, 0, 6'd0));
      send_item(mk(CMD_LOOKUP, k_a, '0, 0, BOUND_UPPER, 6'd0, 0, 0, 6'd0));
      send_item(mk(CMD_STORE, k_a, 25'h1FF_FFFF, 32767, BOUND_EXACT, 6'd63, 0, 0, 6'd63));
      send_item(mk(CMD_PROBE, k_a, '0, 0, BOUND_UPPER, 6'd63, 0, 0, 6'd0));
      send_item(mk(CMD_PROBE, k_a, '0, 0, BOUND_UPPER, 6'd0, 0, 0, 6'd63));
      send_item(mk(CMD_STORE, k_b, 25'd1, -32768, BOUND_UPPER, 6'd10, 0, 0, 6'd63));
      send_item(mk(CMD_PROBE, k_b, '0, 0, BOUND_UPPER, 6'd10, 32000, -32000, 6'd0));
      send_item(mk(CMD_PROBE, k_b, '0, 0, BOUND_UPPER, 6'd10, -32000, 32000, 6'd63));
      send_item(mk(CMD_PROBE, k_b, '0, 0, BOUND_UPPER, 6'd11, 32000, 32000, 6'd0));
      send_item(mk(CMD_PROBE, k_c, '0, 0, BOUND_UPPER, 6'd0, 0, 0, 6'd0));
      send_item(mk(CMD_STORE, k_c, '0, 100, BOUND_LOWER, 6'd5, 0, 0, 6'd0));
      send_item(mk(CMD_PROBE, k_c, '0, 0, BOUND_UPPER, 6'd5, 0, -32000, 6'd0));
      send_item(mk(CMD_PROBE, k_c, '0, 0, BOUND_UPPER, 6'd5, 0, 32000, 6'd0));
      send_item(mk(CMD_STORE, k_d, 25'd12345, 31000, BOUND_EXACT, 6'd3, 0, 0, 6'd10));
      send_item(mk(CMD_PROBE, k_d, '0, 0, BOUND_UPPER, 6'd3, 0, 0, 6'd20));
      send_item(mk(CMD_STORE, k_d, 25'd54321, -31000, BOUND_NONE, 6'd3, 0, 0, 6'd5));
      send_item(mk(CMD_PROBE, k_d, '0, 0, BOUND_UPPER, 6'd0, 32000, -32000, 6'd5));
      send_item(mk(CMD_LOOKUP, k_d, '0, 0, BOUND_UPPER, 6'd0, 0, 0, 6'd0));
      send_item(mk(CMD_STORE, '0, 25'd7, 5, BOUND_EXACT, 6'd1, 0, 0, 6'd0));
      send_item(mk(CMD_STORE, '0, 25'd9, -5, BOUND_LOWER, 6'd2, 0, 0, 6'd0));
      send_item(mk(CMD_UNUSED_LO, k_b, 25'd3, 7, BOUND_EXACT, 6'd1, 1, 2, 6'd3));
      send_item(mk(CMD_UNUSED_HI, k_a, 25'd3, 7, BOUND_EXACT, 6'd1, 1, 2, 6'd3));
      send_item(mk(CMD_OCC, '0, '0, 0, BOUND_UPPER, 6'd0, 0, 0, 6'd0));
      send_item(mk(CMD_CLEAR, '0, '0, 0, BOUND_UPPER, 6'd0, 0, 0, 6'd0));
      send_item(mk(CMD_OCC, '0, '0, 0, BOUND_UPPER, 6'd0, 0, 0, 6'd0));
      send_item(mk(CMD_PROBE, k_a, '0, 0, BOUND_UPPER, 6'd0, 0, 0, 6'd0));

      for (int ph = 0; ph < 4; ph++) begin
         write_threshold(first_thr[ph]);
         tx_idle_pct  = tx_pct[ph];
         rx_stall_pct = rx_pct[ph];
         run_random(ITEMS_PER_LEG);
         if (ph == 1) pressure_burst();
         write_threshold(second_thr[ph]);
         run_random(ITEMS_PER_LEG);
      end

      release_req();
      wait_drain();
      repeat (16) @(posedge clock);
      if (sb.expected_rsp.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, sb.expected_rsp.size());
         sb.errors++;
      end
      $display("run covered %0d requests, %0d responses checked, %0d probe hits,",
               items_sent, sb.checked, sb.hits);
      $display("%0d threshold writes, %0d overwrites and a long response hold-off",
               sb.thr_writes, sb.overwrites);
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
